>>> hdl/sbpr_pkg.sv
`default_nettype none

package sbpr_pkg;

  // Fixed limits of the painter
  localparam int MAX_BINS    = 65536;
  localparam int MAX_COLUMNS = 4096;

  localparam logic [12:0]        COLUMN_SAT = 13'h1FFF;
  localparam logic signed [15:0] PEAK_MIN   = 16'sh8000;
  localparam logic [7:0]         COLOUR_MAX = 8'hFF;

  // Configuration register indexes
  typedef enum logic [3:0] {
    REG_COLUMN_ORIGIN = 4'd0,
    REG_COLUMN_STEP   = 4'd1,
    REG_FIRST_BIN     = 4'd2,
    REG_FINAL_BIN     = 4'd3,
    REG_RUN_EXTRA     = 4'd4,
    REG_LINE_WIDTH    = 4'd5,
    REG_POWER_FLOOR   = 4'd6,
    REG_POWER_GAIN    = 4'd7
  } sbpr_reg_t;

  // One bin after column mapping
  typedef struct packed {
    logic               valid;
    logic               visible;
    logic               last_bin;
    logic [12:0]        column;
    logic signed [15:0] power;
  } sbpr_bin_t;

  // One closed run, colour not yet quantized
  typedef struct packed {
    logic               valid;
    logic               line_done;
    logic [11:0]        run_start;
    logic [11:0]        run_end;
    logic signed [15:0] peak;
  } sbpr_event_t;

  // One finished result item
  typedef struct packed {
    logic        line_done;
    logic [7:0]  colour_index;
    logic [11:0] run_end;
    logic [11:0] run_start;
  } sbpr_result_t;

  // Clamp (peak - floor) * gain, Q18.24, to a colour index
  function automatic logic [7:0] colour_of(input logic signed [41:0] prod);
    logic [7:0] c;
    if (prod[41]) begin
      c = '0;
    end else if (|prod[40:32]) begin
      c = COLOUR_MAX;
    end else begin
      c = prod[31:24];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sbpr_result_fifo.sv
`default_nettype none

// Result queue with two write ports (written in port order) and one read port.
// DEPTH must be a power of two.
module sbpr_result_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr0_en,
  input  wire logic [WIDTH-1:0] wr0_data,
  input  wire logic             wr1_en,
  input  wire logic [WIDTH-1:0] wr1_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             rd_xfer;
  logic [1:0]       n_wr;
  logic [WIDTH-1:0] first_data;

  assign rd_valid   = (count != '0);
  assign rd_data    = mem[rptr];
  assign rd_xfer    = rd_valid && rd_ready;
  assign n_wr       = {1'b0, wr0_en} + {1'b0, wr1_en};
  assign first_data = wr0_en ? wr0_data : wr1_data;

  // storage, compacted writes
  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      mem[wptr] <= first_data;
    end
    if (n_wr == 2'd2) begin
      mem[wptr + AW'(1)] <= wr1_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(n_wr);
      rptr  <= rptr + AW'(rd_xfer);
      count <= count + CW'(n_wr) - CW'(rd_xfer);
    end
  end

endmodule

`default_nettype wire

>>> hdl/sbpr_hold.sv
`default_nettype none

// Peak hold per column; closes a run on a column change and flushes at the final bin.
module sbpr_hold (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sbpr_pkg::sbpr_bin_t bin,
  input  wire logic [11:0]         run_extra,
  input  wire logic [13:0]         col_limit,
  output logic                     item_valid,
  output sbpr_pkg::sbpr_event_t    ev_close,
  output sbpr_pkg::sbpr_event_t    ev_flush
);

  logic [12:0]        held_column;
  logic signed [15:0] held_peak;
  logic               run_open;

  logic [12:0]        held_column_next;
  logic signed [15:0] held_peak_next;
  logic               run_open_next;

  logic               take;
  logic               changed;
  logic               restart;
  logic [12:0]        hc_n;
  logic signed [15:0] hp_n;
  sbpr_pkg::sbpr_event_t close_next;
  sbpr_pkg::sbpr_event_t flush_next;

  // last column of a run, limited to the line
  function automatic logic [11:0] stop_of(input logic [12:0] c, input logic [11:0] extra,
                                          input logic [13:0] lim);
    logic [13:0] sum;
    logic [13:0] lim_m1;
    sum    = {1'b0, c} + {2'b00, extra};
    lim_m1 = lim - 14'd1;
    return (sum > lim_m1) ? lim_m1[11:0] : sum[11:0];
  endfunction

  // hold update and run closing
  always_comb begin
    take    = bin.valid && bin.visible;
    changed = run_open && (bin.column != held_column);
    restart = !run_open || changed;
    hc_n    = restart ? bin.column : held_column;
    if (restart || (bin.power > held_peak)) begin
      hp_n = bin.power;
    end else begin
      hp_n = held_peak;
    end

    close_next.valid     = take && changed && ({1'b0, held_column} < col_limit);
    close_next.line_done = 1'b0;
    close_next.run_start = held_column[11:0];
    close_next.run_end   = stop_of(held_column, run_extra, col_limit);
    close_next.peak      = held_peak;

    flush_next.valid     = take && bin.last_bin && ({1'b0, hc_n} < col_limit);
    flush_next.line_done = 1'b1;
    flush_next.run_start = hc_n[11:0];
    flush_next.run_end   = stop_of(hc_n, run_extra, col_limit);
    flush_next.peak      = hp_n;

    held_column_next = held_column;
    held_peak_next   = held_peak;
    run_open_next    = run_open;
    if (take) begin
      if (bin.last_bin) begin
        held_column_next = '0;
        held_peak_next   = sbpr_pkg::PEAK_MIN;
        run_open_next    = 1'b0;
      end else begin
        held_column_next = hc_n;
        held_peak_next   = hp_n;
        run_open_next    = 1'b1;
      end
    end
  end

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_column <= '0;
      held_peak   <= sbpr_pkg::PEAK_MIN;
      run_open    <= 1'b0;
    end else begin
      held_column <= held_column_next;
      held_peak   <= held_peak_next;
      run_open    <= run_open_next;
    end
  end

  // event register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid     <= 1'b0;
      ev_close.valid <= 1'b0;
      ev_flush.valid <= 1'b0;
    end else begin
      item_valid     <= bin.valid;
      ev_close.valid <= close_next.valid;
      ev_flush.valid <= flush_next.valid;
    end
    ev_close.line_done <= close_next.line_done;
    ev_close.run_start <= close_next.run_start;
    ev_close.run_end   <= close_next.run_end;
    ev_close.peak      <= close_next.peak;
    ev_flush.line_done <= flush_next.line_done;
    ev_flush.run_start <= flush_next.run_start;
    ev_flush.run_end   <= flush_next.run_end;
    ev_flush.peak      <= flush_next.peak;
  end

  // a final visible bin always leaves the hold closed
  a_flush_closes: assert property (@(posedge clk) disable iff (rst)
    (bin.valid && bin.visible && bin.last_bin) |=> !run_open)
    else $error("hold still open after final bin");

  // events only come out of a valid item
  a_event_item: assert property (@(posedge clk) disable iff (rst)
    (ev_close.valid || ev_flush.valid) |-> item_valid)
    else $error("run event without an item");

  // a closed run is never empty
  a_run_order: assert property (@(posedge clk) disable iff (rst)
    ev_close.valid |-> (ev_close.run_start <= ev_close.run_end))
    else $error("closed run is empty");

  // a column change closes a run; a new line has nothing to close
  a_close_needs_hold: assert property (@(posedge clk) disable iff (rst)
    (bin.valid && !run_open) |=> !ev_close.valid)
    else $error("run closed with no hold open");

endmodule

`default_nettype wire

>>> hdl/spectrum_bins_to_pixel_runs.sv
`default_nettype none

// Spectrum bins to pixel runs. Takes one FFT bin (index, Q8.8 power) per clock on
// s_axis, maps it to a display column, peak-holds bins on the same column and emits
// a pixel run (start, inclusive end, colour index) on m_axis when the column changes;
// the bin whose index equals final_bin flushes the last run with tlast set. A bin can
// yield two runs. Throughput is one bin per cycle while s_axis_tready is high; a run
// reaches m_axis through an input register, a column multiplier stage, an origin add,
// the hold stage, a colour multiplier stage and the result queue. s_axis_tready falls
// only while the queue (FIFO_DEPTH entries, two reserved per bin in flight) cannot
// take two more runs, i.e. when m_axis is stalled. There is no clearing pass after
// reset. Configuration writes are taken at any time and are meant for idle periods.
module spectrum_bins_to_pixel_runs #(
  parameter int FIFO_DEPTH = 16  // power of two, at least 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] bin_index, [31:16] bin_power
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [11:0] run_start, [23:12] run_end,
                                           // [31:24] colour_index
  output logic             m_axis_tlast,   // line_done
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [35:0] cfg_data
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  // configuration registers
  logic signed [35:0] column_origin;
  logic [31:0]        column_step;
  logic [15:0]        first_bin;
  logic [15:0]        final_bin;
  logic [11:0]        run_extra;
  logic [12:0]        line_width;
  logic signed [15:0] power_floor;
  logic [23:0]        power_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_origin <= '0;
      column_step   <= 32'd65536;
      first_bin     <= '0;
      final_bin     <= 16'hFFFF;
      run_extra     <= 12'd1;
      line_width    <= 13'd4096;
      power_floor   <= sbpr_pkg::PEAK_MIN;
      power_gain    <= 24'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sbpr_pkg::sbpr_reg_t'(cfg_index))
        sbpr_pkg::REG_COLUMN_ORIGIN: column_origin <= cfg_data;
        sbpr_pkg::REG_COLUMN_STEP:   column_step   <= cfg_data[31:0];
        sbpr_pkg::REG_FIRST_BIN:     first_bin     <= cfg_data[15:0];
        sbpr_pkg::REG_FINAL_BIN:     final_bin     <= cfg_data[15:0];
        sbpr_pkg::REG_RUN_EXTRA:     run_extra     <= cfg_data[11:0];
        sbpr_pkg::REG_LINE_WIDTH:    line_width    <= cfg_data[12:0];
        sbpr_pkg::REG_POWER_FLOOR:   power_floor   <= cfg_data[15:0];
        sbpr_pkg::REG_POWER_GAIN:    power_gain    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // usable columns: min(line_width, MAX_COLUMNS)
  logic [13:0] col_limit;
  assign col_limit = ({1'b0, line_width} < 14'(sbpr_pkg::MAX_COLUMNS)) ?
                     {1'b0, line_width} : 14'(sbpr_pkg::MAX_COLUMNS);

  // queue reservation: two slots per bin in flight plus queued runs
  logic [CW-1:0] slots_used;
  logic          in_xfer;
  logic          out_xfer;

  assign s_axis_tready = (slots_used <= CW'(FIFO_DEPTH - 2));
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // stage 1: input register
  logic        v1;
  logic [15:0] idx1;
  logic [15:0] pwr1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_xfer;
    end
    idx1 <= s_axis_tdata[15:0];
    pwr1 <= s_axis_tdata[31:16];
  end

  // stage 2: bin range check and index * step
  logic        v2;
  logic        vis2;
  logic        last2;
  logic [47:0] prod2;
  logic [15:0] pwr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    vis2  <= (idx1 >= first_bin) && (idx1 <= final_bin) &&
             ({1'b0, idx1} < 17'(sbpr_pkg::MAX_BINS));
    last2 <= (idx1 == final_bin);
    prod2 <= 48'(idx1) * 48'(column_step);
    pwr2  <= pwr1;
  end

  // stage 3: add origin, saturate to a column
  logic signed [49:0] pos;
  logic [12:0]        col_now;
  sbpr_pkg::sbpr_bin_t bin3;

  always_comb begin
    pos = {{14{column_origin[35]}}, column_origin} + $signed({2'b00, prod2});
    if (pos[49]) begin
      col_now = '0;
    end else if (|pos[48:29]) begin
      col_now = sbpr_pkg::COLUMN_SAT;
    end else begin
      col_now = pos[28:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin3.valid <= 1'b0;
    end else begin
      bin3.valid <= v2;
    end
    bin3.visible  <= vis2;
    bin3.last_bin <= last2;
    bin3.column   <= col_now;
    bin3.power    <= pwr2;
  end

  // stage 4: peak hold
  logic                  v4;
  sbpr_pkg::sbpr_event_t ev4_close;
  sbpr_pkg::sbpr_event_t ev4_flush;

  sbpr_hold u_hold (
    .clk        (clk),
    .rst        (rst),
    .bin        (bin3),
    .run_extra  (run_extra),
    .col_limit  (col_limit),
    .item_valid (v4),
    .ev_close   (ev4_close),
    .ev_flush   (ev4_flush)
  );

  // stage 5: colour products for both runs
  logic                  v5;
  sbpr_pkg::sbpr_event_t ev5_close;
  sbpr_pkg::sbpr_event_t ev5_flush;
  logic signed [41:0]    cprod_close;
  logic signed [41:0]    cprod_flush;
  logic signed [16:0]    diff_close;
  logic signed [16:0]    diff_flush;
  logic signed [24:0]    gain_s;

  assign gain_s     = $signed({1'b0, power_gain});
  assign diff_close = {ev4_close.peak[15], ev4_close.peak} - {power_floor[15], power_floor};
  assign diff_flush = {ev4_flush.peak[15], ev4_flush.peak} - {power_floor[15], power_floor};

  always_ff @(posedge clk) begin
    if (rst) begin
      v5              <= 1'b0;
      ev5_close.valid <= 1'b0;
      ev5_flush.valid <= 1'b0;
    end else begin
      v5              <= v4;
      ev5_close.valid <= ev4_close.valid;
      ev5_flush.valid <= ev4_flush.valid;
    end
    ev5_close.line_done <= ev4_close.line_done;
    ev5_close.run_start <= ev4_close.run_start;
    ev5_close.run_end   <= ev4_close.run_end;
    ev5_close.peak      <= ev4_close.peak;
    ev5_flush.line_done <= ev4_flush.line_done;
    ev5_flush.run_start <= ev4_flush.run_start;
    ev5_flush.run_end   <= ev4_flush.run_end;
    ev5_flush.peak      <= ev4_flush.peak;
    cprod_close         <= 42'(diff_close * gain_s);
    cprod_flush         <= 42'(diff_flush * gain_s);
  end

  // clamp and queue, close run ahead of flush run
  sbpr_pkg::sbpr_result_t res_close;
  sbpr_pkg::sbpr_result_t res_flush;
  sbpr_pkg::sbpr_result_t res_head;

  always_comb begin
    res_close.line_done    = ev5_close.line_done;
    res_close.colour_index = sbpr_pkg::colour_of(cprod_close);
    res_close.run_end      = ev5_close.run_end;
    res_close.run_start    = ev5_close.run_start;
    res_flush.line_done    = ev5_flush.line_done;
    res_flush.colour_index = sbpr_pkg::colour_of(cprod_flush);
    res_flush.run_end      = ev5_flush.run_end;
    res_flush.run_start    = ev5_flush.run_start;
  end

  sbpr_result_fifo #(
    .WIDTH ($bits(sbpr_pkg::sbpr_result_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr0_en   (ev5_close.valid),
    .wr0_data (res_close),
    .wr1_en   (ev5_flush.valid),
    .wr1_data (res_flush),
    .rd_valid (m_axis_tvalid),
    .rd_ready (m_axis_tready),
    .rd_data  (res_head)
  );

  assign m_axis_tdata = {res_head.colour_index, res_head.run_end, res_head.run_start};
  assign m_axis_tlast = res_head.line_done;
  assign out_xfer     = m_axis_tvalid && m_axis_tready;

  // release the unused part of a bin's two slots when it reaches the queue
  logic [1:0] release_cnt;
  assign release_cnt = v5 ? (2'd2 - {1'b0, ev5_close.valid} - {1'b0, ev5_flush.valid})
                          : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
    end else begin
      slots_used <= slots_used + (in_xfer ? CW'(2) : CW'(0)) - CW'(release_cnt)
                    - CW'(out_xfer);
    end
  end

endmodule

`default_nettype wire
